// File: design/ihd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ihd_pkg: shared constants for the impact hit detector
// Parameter defaults, field widths, configuration register indexes, reset values and event codes.
// ----------------------------------------------------------------------------
package ihd_pkg;

  // Parameter defaults
  localparam int SAMPLES_DEF  = 16;
  localparam int ADC_BITS_DEF = 12;

  // Fixed field widths
  localparam int SAMPLE_W = 12;
  localparam int BASE_W   = 12;
  localparam int TIME_W   = 32;
  localparam int CODE_W   = 2;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int THR_W    = 12;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CALIB_TIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIG_LEVEL  = 2'd3;

  // Configuration reset values
  localparam logic [CFG_W-1:0]   CALIB_TIME_RST = 16'd1000;
  localparam logic [THR_W-1:0]   THRESHOLD_RST  = 12'd200;
  localparam logic [CFG_W-1:0]   COOLDOWN_RST   = 16'd100;
  localparam logic               DIG_LEVEL_RST  = 1'b1;

  // Event code bits
  localparam logic [CODE_W-1:0] CODE_NONE    = 2'd0;
  localparam logic [CODE_W-1:0] CODE_DIGITAL = 2'd1;
  localparam logic [CODE_W-1:0] CODE_ANALOG  = 2'd2;

endpackage
`default_nettype wire

// File: design/impact_hit_detector.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// impact_hit_detector: moving-average baseline and hit detector
// Sequence: calibration words go evaluate, 12-step bit-serial divide, divide
//   wrap-up, output load; detection words go evaluate, hit check, output load;
//   restart words go evaluate, output load.
// Throughput: one word at a time; the next word is accepted the cycle after
//   the result moves to the output register, which waits out any output stall.
// Reset: control state and configuration return to defaults; the sample ring
//   is not cleared and is read only after being written since a restart.
// ----------------------------------------------------------------------------
module impact_hit_detector #(
  parameter int SAMPLES  = ihd_pkg::SAMPLES_DEF,
  parameter int ADC_BITS = ihd_pkg::ADC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          restart_i,
  input  wire logic [ihd_pkg::TIME_W-1:0]    time_ms_i,
  input  wire logic [ihd_pkg::SAMPLE_W-1:0]  sample_i,
  input  wire logic                          digital_level_i,
  // output channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [ihd_pkg::CODE_W-1:0]         hit_code_o,
  output logic                               calibrating_o,
  output logic [ihd_pkg::BASE_W-1:0]         baseline_level_o,
  // configuration
  input  wire logic                          cfg_we_i,
  input  wire logic [ihd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [ihd_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import ihd_pkg::*;

  localparam int CNT_W  = $clog2(SAMPLES + 1);
  localparam int PTR_W  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int SUM_W  = SAMPLE_W + CNT_W;
  localparam int MASK_W = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
  localparam logic [SAMPLE_W-1:0] ADC_MASK = SAMPLE_W'((32'd1 << MASK_W) - 32'd1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_HIT  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  // Configuration registers
  logic [CFG_W-1:0] calib_time_q, cooldown_q;
  logic [THR_W-1:0] threshold_q;
  logic             dig_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_time_q <= CALIB_TIME_RST;
      threshold_q  <= THRESHOLD_RST;
      cooldown_q   <= COOLDOWN_RST;
      dig_level_q  <= DIG_LEVEL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CALIB_TIME: calib_time_q <= cfg_wdata_i;
        CFG_THRESHOLD:  threshold_q  <= cfg_wdata_i[THR_W-1:0];
        CFG_COOLDOWN:   cooldown_q   <= cfg_wdata_i;
        CFG_DIG_LEVEL:  dig_level_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Control and detector state
  logic [2:0]          state_q, state_d;
  logic                ready_q, ready_d;
  logic [TIME_W-1:0]   calib_start_q, calib_start_d;
  logic [BASE_W-1:0]   baseline_q, baseline_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [CNT_W-1:0]    fill_q, fill_d;
  logic [PTR_W-1:0]    pos_q, pos_d;
  logic [TIME_W-1:0]   last_hit_q, last_hit_d;
  logic                prev_dig_q, prev_dig_d;
  logic                prev_ana_q, prev_ana_d;

  // Latched input word
  logic                w_restart_q;
  logic [TIME_W-1:0]   w_time_q;
  logic [SAMPLE_W-1:0] w_adc_q;
  logic                w_dx_q;

  // Pending result
  logic [CODE_W-1:0]   res_code_q, res_code_d;
  logic                res_cal_q, res_cal_d;
  logic [BASE_W-1:0]   res_base_q, res_base_d;

  // Output register
  logic                out_valid_q;
  logic [CODE_W-1:0]   out_code_q;
  logic                out_cal_q;
  logic [BASE_W-1:0]   out_base_q;

  logic                in_acc;
  logic                out_ld;
  logic                ring_we;
  logic [SAMPLE_W-1:0] ring_rd_q;
  logic                div_start;
  logic                div_done;
  logic [BASE_W-1:0]   div_quot;
  logic [TIME_W-1:0]   calib_elapsed, hit_elapsed;
  logic [BASE_W:0]     ana_limit;
  logic                ax_high, cool_ok, hit;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_ld     = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  // Sample ring: one write and one registered read per cycle
  logic [SAMPLE_W-1:0] ring_mem [SAMPLES];

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[pos_q] <= w_adc_q;
    end
    ring_rd_q <= ring_mem[pos_q];
  end

  // Latch the accepted word
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      w_restart_q <= restart_i;
      w_time_q    <= time_ms_i;
      w_adc_q     <= sample_i & ADC_MASK;
      w_dx_q      <= (digital_level_i == dig_level_q);
    end
  end

  // Time and threshold compares
  always_comb begin
    calib_elapsed = w_time_q - calib_start_q;
    hit_elapsed   = w_time_q - last_hit_q;
    ana_limit     = {1'b0, baseline_q} + {1'b0, threshold_q};
    ax_high       = {1'b0, w_adc_q} > ana_limit;
    cool_ok       = hit_elapsed >= {{(TIME_W-CFG_W){1'b0}}, cooldown_q};
    hit           = cool_ok && ((w_dx_q && !prev_dig_q) || (ax_high && !prev_ana_q));
  end

  // Sequencer
  always_comb begin
    state_d       = state_q;
    ready_d       = ready_q;
    calib_start_d = calib_start_q;
    baseline_d    = baseline_q;
    sum_d         = sum_q;
    fill_d        = fill_q;
    pos_d         = pos_q;
    last_hit_d    = last_hit_q;
    prev_dig_d    = prev_dig_q;
    prev_ana_d    = prev_ana_q;
    res_code_d    = res_code_q;
    res_cal_d     = res_cal_q;
    res_base_d    = res_base_q;
    ring_we       = 1'b0;
    div_start     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        priority if (w_restart_q) begin
          ready_d       = 1'b0;
          calib_start_d = w_time_q;
          baseline_d    = '0;
          sum_d         = '0;
          fill_d        = '0;
          pos_d         = '0;
          last_hit_d    = '0;
          prev_dig_d    = 1'b0;
          prev_ana_d    = 1'b0;
          res_code_d    = CODE_NONE;
          res_cal_d     = 1'b1;
          res_base_d    = '0;
          state_d       = ST_OUT;
        end else if (ready_q) begin
          state_d = ST_HIT;
        end else if (calib_elapsed >= {{(TIME_W-CFG_W){1'b0}}, calib_time_q}) begin
          ready_d = 1'b1;
          state_d = ST_HIT;
        end else begin
          // calibration: slide the window and start the average
          if (fill_q < CNT_W'(SAMPLES)) begin
            fill_d = fill_q + CNT_W'(1);
            sum_d  = sum_q + SUM_W'(w_adc_q);
          end else begin
            sum_d  = sum_q - SUM_W'(ring_rd_q) + SUM_W'(w_adc_q);
          end
          ring_we    = 1'b1;
          pos_d      = (pos_q == PTR_W'(SAMPLES - 1)) ? '0 : pos_q + PTR_W'(1);
          prev_dig_d = w_dx_q;
          prev_ana_d = 1'b0;
          div_start  = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          baseline_d = div_quot;
          res_code_d = CODE_NONE;
          res_cal_d  = 1'b1;
          res_base_d = div_quot;
          state_d    = ST_OUT;
        end
      end
      ST_HIT: begin
        res_code_d = CODE_NONE;
        if (hit) begin
          res_code_d = (w_dx_q ? CODE_DIGITAL : CODE_NONE) | (ax_high ? CODE_ANALOG : CODE_NONE);
          last_hit_d = w_time_q;
        end
        prev_dig_d = w_dx_q;
        prev_ana_d = ax_high;
        res_cal_d  = 1'b0;
        res_base_d = baseline_q;
        state_d    = ST_OUT;
      end
      ST_OUT: begin
        if (out_ld) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      ready_q       <= 1'b0;
      calib_start_q <= '0;
      baseline_q    <= '0;
      sum_q         <= '0;
      fill_q        <= '0;
      pos_q         <= '0;
      last_hit_q    <= '0;
      prev_dig_q    <= 1'b0;
      prev_ana_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      ready_q       <= ready_d;
      calib_start_q <= calib_start_d;
      baseline_q    <= baseline_d;
      sum_q         <= sum_d;
      fill_q        <= fill_d;
      pos_q         <= pos_d;
      last_hit_q    <= last_hit_d;
      prev_dig_q    <= prev_dig_d;
      prev_ana_q    <= prev_ana_d;
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    res_code_q <= res_code_d;
    res_cal_q  <= res_cal_d;
    res_base_q <= res_base_d;
    if (out_ld) begin
      out_code_q <= res_code_q;
      out_cal_q  <= res_cal_q;
      out_base_q <= res_base_q;
    end
  end

  // Baseline average
  ihd_serial_div #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_d),
    .divisor_i  (fill_d),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign out_valid_o      = out_valid_q;
  assign hit_code_o       = out_code_q;
  assign calibrating_o    = out_cal_q;
  assign baseline_level_o = out_base_q;

  // Checks
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide state");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(SAMPLES))
    else $error("fill count exceeds window size");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PTR_W'(SAMPLES - 1))
    else $error("ring position out of range");

  a_hit_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HIT) |-> ready_q)
    else $error("hit evaluation while calibrating");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (fill_q != '0))
    else $error("average started with empty window");

endmodule
`default_nettype wire

// File: design/ihd_serial_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ihd_serial_div: bit-serial restoring divider
// Divides the window sum by the fill count, one quotient bit per cycle.
// The quotient is known to fit BASE_W bits, so the remainder starts from
// the upper part of the dividend and BASE_W steps suffice.
// ----------------------------------------------------------------------------
module ihd_serial_div #(
  parameter int CNT_W = 5,
  parameter int SUM_W = 17
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [SUM_W-1:0]           dividend_i,
  input  wire logic [CNT_W-1:0]           divisor_i,
  output logic                            done_o,
  output logic [ihd_pkg::BASE_W-1:0]      quotient_o
);
  import ihd_pkg::*;

  localparam int STEP_W = $clog2(BASE_W + 1);

  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  dvs_q;
  logic [BASE_W-1:0] lo_q, lo_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W:0]    trial;
  logic              fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_q, lo_q[BASE_W-1]};
    fits  = (trial >= {1'b0, dvs_q});
  end

  always_comb begin
    rem_d  = rem_q;
    lo_d   = lo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i[SUM_W-1 -: CNT_W];
      lo_d   = dividend_i[BASE_W-1:0];
      cnt_d  = STEP_W'(BASE_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? CNT_W'(trial - {1'b0, dvs_q}) : CNT_W'(trial);
      lo_d  = {lo_q[BASE_W-2:0], fits};
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = lo_q;

endmodule
`default_nettype wire
